// File: rtl/core/wnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_pkg - shared types and constants of the wildcard name matcher
// Opcodes, character codes, the cell control word and the links that
// pass prefix-match bits from one cell to the next.
// ----------------------------------------------------------------------------
package wnm_pkg;

  localparam int CHAR_W           = 16;
  localparam int PATTERN_CAP_DEF  = 32;

  localparam logic [CHAR_W-1:0] CH_STAR  = 16'h002A;
  localparam logic [CHAR_W-1:0] CH_QMARK = 16'h003F;

  // Input word kinds carried on tuser
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } opcode_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic              restart;   // return the name state to the empty prefix
    logic              step;      // advance all prefix bits by one name char
    logic              clear;     // drop the stored pattern
    logic              write;     // store one pattern char at the write index
    logic              wstar;     // char being stored is '*'
    logic              wqmark;    // char being stored is '?'
    logic [CHAR_W-1:0] wchar;     // case-folded char being stored
    logic [CHAR_W-1:0] name_char; // case-folded name char
  } cell_ctl_t;

  // Prefix bits handed from a cell to its right neighbor
  typedef struct packed {
    logic closed;  // prefix match after the star step
    logic raw;     // prefix match as registered
  } link_t;

  // One verdict
  typedef struct packed {
    logic wild;
    logic ovf;
    logic matched;
  } verdict_t;

  // Fold ASCII lower case onto upper case
  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[16'h0061:16'h007A]}) begin
      r = c - 16'h0020;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/wnm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_cell - one pattern position of the matcher row
// Holds one pattern char and the match bit of the prefix that ends at it,
// and updates that bit from its left neighbor on every name char.
// ----------------------------------------------------------------------------
module wnm_cell #(
  parameter int IDX_W = 5,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  wnm_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]   wr_index,
  input  wnm_pkg::link_t     left,
  output wnm_pkg::link_t     right,
  output logic               hit
);
  import wnm_pkg::*;

  logic [CHAR_W-1:0] pchar;
  logic              is_star;
  logic              is_qmark;
  logic              valid;
  logic              tail;
  logic              m;
  logic              sel;
  logic              closed_self;
  logic              m_next;

  assign sel = ctl.write && (wr_index == IDX_W'(INDEX));

  // Star step: stars never sit side by side, so one neighbor is enough
  assign closed_self = valid && (m || (is_star && left.raw));

  // Next prefix bit for one name char
  always_comb begin
    m_next = 1'b0;
    if (valid) begin
      if (is_star) begin
        m_next = closed_self;
      end else if (is_qmark) begin
        m_next = left.closed;
      end else begin
        m_next = left.closed && (pchar == ctl.name_char);
      end
    end
  end

  assign right.closed = closed_self;
  assign right.raw    = m;
  assign hit          = tail && closed_self;

  // Hold the pattern char
  always_ff @(posedge clk) begin
    if (sel) begin
      pchar    <= ctl.wchar;
      is_star  <= ctl.wstar;
      is_qmark <= ctl.wqmark;
    end
  end

  // Track occupancy and whether this is the last stored position
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tail  <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
      tail  <= 1'b0;
    end else if (ctl.write) begin
      if (sel) begin
        valid <= 1'b1;
      end
      tail <= sel;
    end
  end

  // Advance the prefix bit
  always_ff @(posedge clk) begin
    if (rst) begin
      m <= 1'b0;
    end else if (ctl.restart) begin
      m <= 1'b0;
    end else if (ctl.step) begin
      m <= m_next;
    end
  end

endmodule

// File: rtl/core/wnm_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_out_buf - verdict output register with skid stage
// Lets the input side keep running while a verdict waits to be taken.
// ----------------------------------------------------------------------------
module wnm_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  wnm_pkg::verdict_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  output wnm_pkg::verdict_t out_data,
  input  logic              out_ready
);
  import wnm_pkg::*;

  verdict_t skid_data;
  logic     skid_valid;

  assign in_ready = !skid_valid;

  // Control: refill from the skid first, else take the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: rtl/core/wildcard_name_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_name_matcher - case-insensitive wildcard match of streamed names
// Top level: input decode, pattern bookkeeping, the cell row and the
// verdict output buffer.
// ----------------------------------------------------------------------------
// An input word can be accepted on each cycle while input is not stalled;
// the row of PATTERN_CAPACITY cells updates all prefix-match bits for a name
// char at once. The verdict for an end-of-name word is registered in the
// output buffer and is held until taken; one further
// verdict is parked in a skid stage, and input stalls only while both are
// full. A '*' appended right after a stored '*' counts toward capacity but is
// not stored, since a run of stars matches like a single star.
module wildcard_name_matcher #(
  parameter int PATTERN_CAPACITY = wnm_pkg::PATTERN_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] char_code
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] matched, [7:1] zero
  output logic [1:0]  m_tuser    // [0] pattern_overflow, [1] name_had_wildcard
);
  import wnm_pkg::*;

  localparam int CNT_W = $clog2(PATTERN_CAPACITY + 1);
  localparam int IDX_W = $clog2(PATTERN_CAPACITY);

  logic                        accept;
  opcode_t                     op;
  logic [CHAR_W-1:0]           fchar;
  logic                        in_star;
  logic                        in_qmark;
  logic                        has_room;
  cell_ctl_t                   ctl;

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            stored_len;
  logic                        last_star;
  logic                        empty;
  logic                        ovf;
  logic                        wild;
  logic                        m0;

  link_t                       start_link;
  link_t                       links [PATTERN_CAPACITY];
  logic [PATTERN_CAPACITY-1:0] hits;

  verdict_t                    verdict;
  verdict_t                    out_verdict;
  logic                        verdict_valid;

  // Decode the input word
  assign accept   = s_tvalid && s_tready;
  assign op       = opcode_t'(s_tuser);
  assign fchar    = fold_case(s_tdata);
  assign in_star  = (s_tdata == CH_STAR);
  assign in_qmark = (s_tdata == CH_QMARK);
  assign has_room = (count < CNT_W'(PATTERN_CAPACITY));

  // Broadcast control to the cells
  always_comb begin
    ctl.restart   = accept && (op != OP_NAME);
    ctl.step      = accept && (op == OP_NAME);
    ctl.clear     = accept && (op == OP_CLEAR);
    ctl.write     = accept && (op == OP_APPEND) && has_room && !(in_star && last_star);
    ctl.wstar     = in_star;
    ctl.wqmark    = in_qmark;
    ctl.wchar     = fchar;
    ctl.name_char = fchar;
  end

  // Pattern bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      stored_len <= '0;
      last_star  <= 1'b0;
      empty      <= 1'b1;
      ovf        <= 1'b0;
    end else if (ctl.clear) begin
      count      <= '0;
      stored_len <= '0;
      last_star  <= 1'b0;
      empty      <= 1'b1;
      ovf        <= 1'b0;
    end else if (accept && (op == OP_APPEND)) begin
      if (has_room) begin
        count <= count + CNT_W'(1);
        if (ctl.write) begin
          stored_len <= stored_len + CNT_W'(1);
          last_star  <= in_star;
          empty      <= 1'b0;
        end
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Name state held at the top: empty-prefix bit and wildcard mark
  always_ff @(posedge clk) begin
    if (rst) begin
      m0   <= 1'b1;
      wild <= 1'b0;
    end else if (ctl.restart) begin
      m0   <= 1'b1;
      wild <= 1'b0;
    end else if (ctl.step) begin
      m0 <= 1'b0;
      if (in_star || in_qmark) begin
        wild <= 1'b1;
      end
    end
  end

  assign start_link.closed = m0;
  assign start_link.raw    = m0;

  // Row of prefix-match cells
  for (genvar j = 0; j < PATTERN_CAPACITY; j++) begin : g_cell
    wnm_cell #(
      .IDX_W (IDX_W),
      .INDEX (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wr_index (stored_len[IDX_W-1:0]),
      .left     ((j == 0) ? start_link : links[(j == 0) ? 0 : j - 1]),
      .right    (links[j]),
      .hit      (hits[j])
    );
  end

  // Form the verdict
  always_comb begin
    verdict.ovf     = ovf;
    verdict.wild    = wild;
    verdict.matched = ((|hits) || (empty && m0)) && !ovf && !wild;
  end

  assign verdict_valid = accept && (op == OP_END);

  wnm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (verdict_valid),
    .in_data   (verdict),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (out_verdict),
    .out_ready (m_tready)
  );

  assign m_tdata = {7'b0, out_verdict.matched};
  assign m_tuser = {out_verdict.wild, out_verdict.ovf};

endmodule

// File: rtl/core/wnm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnm_checker - port-level checks of the wildcard name matcher
// Watches the output stream of the top level and is bound to it.
// ----------------------------------------------------------------------------
module wnm_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);

  // A stalled verdict stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("verdict dropped while stalled");

  // A stalled verdict keeps its value
  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("verdict changed while stalled");

  // A match never comes with an overflowed pattern or a wildcard name
  a_match_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tuser == 2'b00))
    else $error("match reported with overflow or wildcard flag");

  // Padding bits of the verdict stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("nonzero padding in verdict");

  // No verdict is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("verdict offered after reset");

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (.*);

// File: verif/tb_wildcard_name_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_name_matcher - self-checking testbench of the name matcher
// Walks a short directed table (empty pattern, wildcards on both sides, case
// folding, full and overflowed patterns, pattern changes mid-name), then
// streams random patterns and names, most of them built to match. Every
// verdict is checked against a prefix-bit predictor kept in this bench or a
// fixed value of its directed row, with bursty input traffic and a stalling output side.
// ----------------------------------------------------------------------------
module tb_wildcard_name_matcher;
  import wnm_pkg::*;

  localparam int CAP        = PATTERN_CAP_DEF;
  localparam int RAND_WORDS = 1350;

  typedef struct packed {
    bit matched;
    bit overflow;
    bit wild;
  } match_result_t;

  typedef struct packed {
    opcode_t       op;
    logic [15:0]   ch;
    logic [5:0]    reps;
    bit            fixed;
    match_result_t want;
  } stim_row_t;

  localparam match_result_t HIT      = '{1'b1, 1'b0, 1'b0};
  localparam match_result_t MISS     = '{1'b0, 1'b0, 1'b0};
  localparam match_result_t MISS_OVF = '{1'b0, 1'b1, 1'b0};
  localparam match_result_t MISS_WLD = '{1'b0, 1'b0, 1'b1};
  localparam match_result_t NO_WANT  = '0;

  localparam int NROWS = 34;
  localparam stim_row_t DIR_ROWS [NROWS] = '{
    '{OP_END,    16'hFFFF, 6'd1,  1'b1, HIT},      // empty pattern, empty name
    '{OP_NAME,   16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'h0000, 6'd1,  1'b1, MISS},     // empty pattern, one char
    '{OP_APPEND, 16'h0061, 6'd1,  1'b0, NO_WANT},  // pattern "a*?" + NUL
    '{OP_APPEND, 16'h002A, 6'd1,  1'b0, NO_WANT},
    '{OP_APPEND, 16'h003F, 6'd1,  1'b0, NO_WANT},
    '{OP_APPEND, 16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h0041, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h0078, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h0059, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h0061, 6'd1,  1'b0, NO_WANT},  // star inside the name
    '{OP_NAME,   16'h002A, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'h0000, 6'd1,  1'b1, MISS_WLD},
    '{OP_NAME,   16'h0061, 6'd1,  1'b0, NO_WANT},  // append restarts the name
    '{OP_APPEND, 16'h007A, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_CLEAR,  16'hFFFF, 6'd1,  1'b0, NO_WANT},  // one star past capacity
    '{OP_APPEND, 16'h002A, 6'd33, 1'b0, NO_WANT},
    '{OP_NAME,   16'hFFFF, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'hFFFF, 6'd1,  1'b1, MISS_OVF},
    '{OP_CLEAR,  16'h0000, 6'd1,  1'b0, NO_WANT},  // exactly full pattern
    '{OP_APPEND, 16'hFFFF, 6'd32, 1'b0, NO_WANT},
    '{OP_NAME,   16'hFFFF, 6'd32, 1'b0, NO_WANT},
    '{OP_END,    16'hFFFF, 6'd1,  1'b0, NO_WANT},
    '{OP_CLEAR,  16'h0000, 6'd1,  1'b0, NO_WANT},
    '{OP_NAME,   16'h003F, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'h0000, 6'd1,  1'b1, MISS_WLD},
    '{OP_END,    16'h0000, 6'd1,  1'b1, HIT},      // wild flag cleared again
    '{OP_APPEND, 16'h0060, 6'd1,  1'b0, NO_WANT},  // no folding next to letters
    '{OP_NAME,   16'h0040, 6'd1,  1'b0, NO_WANT},
    '{OP_END,    16'h0000, 6'd1,  1'b1, MISS}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [15:0] char_code
  logic [1:0]  s_tuser  = OP_CLEAR;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;   // [0] matched, [7:1] zero
  logic [1:0]  m_tuser;   // [0] pattern_overflow, [1] name_had_wildcard

  // predictor state
  logic [15:0]   pat_mem [CAP];
  int unsigned   pat_cnt   = 0;
  bit            pat_ovf   = 1'b0;
  logic [CAP:0]  live      = (CAP+1)'(1);
  bit            name_wild = 1'b0;

  match_result_t verdicts_due [$];
  logic [15:0]   name_q [$];
  int            err_cnt    = 0;
  int            words_sent = 0;
  int            burst_left = 0;
  int            rx_cyc     = 0;
  int            rx_mode    = 0;

  wildcard_name_matcher DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [15:0] upper_of(input logic [15:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
    return c;
  endfunction

  // let each live prefix ending before a star also cover the star
  function automatic logic [CAP:0] spread_stars(input logic [CAP:0] v);
    for (int j = 0; j < pat_cnt; j++) begin
      if (v[j] && pat_mem[j] == CH_STAR) v[j+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic void restart_name();
    live      = (CAP+1)'(1);
    name_wild = 1'b0;
  endfunction

  // advance the predictor by one word; return 1 when a verdict is due
  function automatic bit predict_verdict(input opcode_t op, input logic [15:0] ch,
                                         output match_result_t res);
    logic [CAP:0] cur;
    logic [CAP:0] nxt;
    logic [CAP:0] fin;
    res = '0;
    case (op)
      OP_CLEAR: begin
        pat_cnt = 0;
        pat_ovf = 1'b0;
        restart_name();
      end
      OP_APPEND: begin
        if (pat_cnt < CAP) begin
          pat_mem[pat_cnt] = ch;
          pat_cnt++;
        end else begin
          pat_ovf = 1'b1;
        end
        restart_name();
      end
      OP_NAME: begin
        if (ch == CH_STAR || ch == CH_QMARK) name_wild = 1'b1;
        cur = spread_stars(live);
        nxt = '0;
        for (int j = 0; j < pat_cnt; j++) begin
          if (pat_mem[j] == CH_STAR) nxt[j+1] = cur[j+1];
          else if (pat_mem[j] == CH_QMARK) nxt[j+1] = cur[j];
          else nxt[j+1] = cur[j] && (upper_of(pat_mem[j]) == upper_of(ch));
        end
        live = nxt;
      end
      default: begin
        fin = spread_stars(live);
        res.matched  = fin[pat_cnt] && !pat_ovf && !name_wild;
        res.overflow = pat_ovf;
        res.wild     = name_wild;
        restart_name();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // pick characters biased toward letters and case-fold boundaries
  function automatic logic [15:0] rand_char();
    logic [15:0] c;
    case ($urandom_range(0, 7))
      0: c = 16'($urandom);
      1: c = 16'($urandom_range(16'h0041, 16'h005A));
      2: c = 16'($urandom_range(16'h0061, 16'h007A));
      3: begin
        case ($urandom_range(0, 7))
          0: c = 16'h0040;
          1: c = 16'h0060;
          2: c = 16'h005B;
          3: c = 16'h007B;
          4: c = 16'h0000;
          5: c = 16'hFFFF;
          6: c = 16'h005A;
          default: c = 16'h007A;
        endcase
      end
      default: c = 16'($urandom_range(16'h0061, 16'h0064)) ^ (16'($urandom_range(0, 1)) << 5);
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rand_pat_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CH_STAR;
    if (r < 25) return CH_QMARK;
    return rand_char();
  endfunction

  function automatic logic [15:0] rand_name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return CH_STAR;
    if (r < 3) return CH_QMARK;
    return rand_char();
  endfunction

  // swap the case of a letter half of the time
  function automatic logic [15:0] maybe_flip(input logic [15:0] c);
    if (((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A))
        && $urandom_range(0, 1) == 1) return c ^ 16'h0020;
    return c;
  endfunction

  // drive one word in bursts with random gaps, then predict
  task automatic send_word(input opcode_t op, input logic [15:0] ch, input bit fixed,
                           input match_result_t want);
    match_result_t res;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ch;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    words_sent++;
    if (predict_verdict(op, ch, res)) verdicts_due.push_back(fixed ? want : res);
  endtask

  // hold off input until every verdict has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic send_pattern();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 7);
    send_word(OP_CLEAR, 16'($urandom), 1'b0, NO_WANT);
    repeat (len) send_word(OP_APPEND, rand_pat_char(), 1'b0, NO_WANT);
  endtask

  // build a name, mostly derived from the current pattern, and stream it
  task automatic send_name();
    int idx;
    name_q.delete();
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < pat_cnt; k++) begin
        if (pat_mem[k] == CH_STAR) repeat ($urandom_range(0, 3)) name_q.push_back(rand_char());
        else if (pat_mem[k] == CH_QMARK) name_q.push_back(rand_char());
        else name_q.push_back(maybe_flip(pat_mem[k]));
      end
    end else begin
      repeat ($urandom_range(0, 6)) name_q.push_back(rand_name_char());
    end
    // perturb some names so near misses show up
    case ($urandom_range(0, 9))
      0: if (name_q.size() > 0) begin
        idx = $urandom_range(0, name_q.size() - 1);
        name_q[idx] = rand_name_char();
      end
      1: if (name_q.size() > 0) name_q.delete($urandom_range(0, name_q.size() - 1));
      2: name_q.insert($urandom_range(0, name_q.size()), rand_name_char());
      default: ;
    endcase
    foreach (name_q[i]) begin
      if ($urandom_range(0, 39) == 0) send_word(OP_APPEND, rand_pat_char(), 1'b0, NO_WANT);
      send_word(OP_NAME, name_q[i], 1'b0, NO_WANT);
    end
    if ($urandom_range(0, 19) != 0) send_word(OP_END, 16'($urandom), 1'b0, NO_WANT);
  endtask

  // receiver: stall on a randomly chosen pattern; check verdicts
  always @(posedge clk) begin
    match_result_t exp_v;
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (rx_cyc % 5) != 0;
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
    if (!rst && m_tvalid && m_tready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict with none due: tdata=%h tuser=%b", m_tdata, m_tuser);
        err_cnt++;
      end else begin
        exp_v = verdicts_due.pop_front();
        if (m_tdata[0] !== exp_v.matched) begin
          $error("matched: expected %0d, got %0d", exp_v.matched, m_tdata[0]);
          err_cnt++;
        end
        if (m_tuser[0] !== exp_v.overflow) begin
          $error("pattern_overflow: expected %0d, got %0d", exp_v.overflow, m_tuser[0]);
          err_cnt++;
        end
        if (m_tuser[1] !== exp_v.wild) begin
          $error("name_had_wildcard: expected %0d, got %0d", exp_v.wild, m_tuser[1]);
          err_cnt++;
        end
        if (m_tdata[7:1] !== 7'd0) begin
          $error("tdata pad: expected 0, got %h", m_tdata[7:1]);
          err_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int next_hold;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NROWS; i++) begin
      repeat (DIR_ROWS[i].reps)
        send_word(DIR_ROWS[i].op, DIR_ROWS[i].ch, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
    end
    drain();

    words_sent = 0;
    next_hold  = 300;
    while (words_sent < RAND_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_pattern();
        3: send_word(opcode_t'($urandom_range(0, 3)), 16'($urandom), 1'b0, NO_WANT);
        default: ;
      endcase
      send_name();
      if (words_sent >= next_hold) begin
        drain();
        next_hold += 300;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_wildcard_name_matcher: clean");
    end else begin
      $display("tb_wildcard_name_matcher: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_wildcard_name_matcher: errors");
    $finish;
  end

endmodule
